// ===== rtl/pbks_pkg.sv =====
// Shared types and codes for the playback transport keyframe seek block.
`default_nettype none

package pbks_pkg;

  // Command codes carried in the cmd field.
  localparam logic [2:0] CMD_WRITE_ENTRY = 3'd0;
  localparam logic [2:0] CMD_RESTART     = 3'd1;
  localparam logic [2:0] CMD_PLAY_PAUSE  = 3'd2;
  localparam logic [2:0] CMD_SKIP_FWD    = 3'd3;
  localparam logic [2:0] CMD_SKIP_BACK   = 3'd4;
  localparam logic [2:0] CMD_TICK        = 3'd5;

  // Playback modes.
  localparam logic [1:0] MODE_PAUSED  = 2'd0;
  localparam logic [1:0] MODE_PLAYING = 2'd1;
  localparam logic [1:0] MODE_ENDED   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SKIP_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_FRAME_COUNT    = 2'd1;
  localparam logic [1:0] CFG_KEYFRAME_COUNT = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  entry_slot;
    logic [31:0] entry_frame;
    logic [31:0] entry_offset;
    logic        frame_ready;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [1:0]  play_state;
    logic [31:0] shown_frame;
    logic        seek_valid;
    logic [31:0] seek_offset;
    logic        frame_advanced;
    logic        reached_end;
    logic [7:0]  current_keyframe;
  } out_item_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD = 2'b01,
    ALU_SUB = 2'b10
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        carry;  // Carry out for add, borrow for subtract.
    logic        zero;
  } alu_rsp_t;

  // Keyframe table access: write and read share one slot address.
  typedef struct packed {
    logic        we;
    logic        re;
    logic [8:0]  slot;
    logic [31:0] frame;
    logic [31:0] offset;
  } kf_req_t;

endpackage

`default_nettype wire

// ===== rtl/pbks_alu.sv =====
// Shared 32-bit add and subtract unit with borrow and zero flags.
`default_nettype none

module pbks_alu
  import pbks_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [32:0] sum;

  // One adder serves both operations; compares use the borrow and zero flags.
  always_comb begin
    case (req.op)
      ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
      default: sum = {1'b0, req.a} + {1'b0, req.b};
    endcase
  end

  assign rsp.res   = sum[31:0];
  assign rsp.carry = sum[32];
  assign rsp.zero  = (sum[31:0] == 32'd0);

endmodule

`default_nettype wire

// ===== rtl/pbks_kfmem.sv =====
// Keyframe table memory holding frame numbers and byte offsets per slot.
`default_nettype none

module pbks_kfmem
  import pbks_pkg::*;
#(
  parameter int MAX_KEYFRAMES = 256
) (
  input  logic        clk,
  input  kf_req_t     req,
  output logic [31:0] rd_frame,
  output logic [31:0] rd_offset
);

  localparam int AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int SW = ((AW > 9) ? AW : 9) + 1;
  localparam logic [SW-1:0] DEPTH = SW'(MAX_KEYFRAMES);

  logic [31:0]   frames  [MAX_KEYFRAMES];
  logic [31:0]   offsets [MAX_KEYFRAMES];
  logic [SW-1:0] slot_ext;
  logic [AW-1:0] addr;
  logic          in_range;
  logic          rd_oob;
  logic [31:0]   frame_q;
  logic [31:0]   offset_q;

  assign slot_ext = SW'(req.slot);
  assign addr     = slot_ext[AW-1:0];
  assign in_range = (slot_ext < DEPTH);

  // Write port: slots past the table depth are dropped.
  always_ff @(posedge clk) begin
    if (req.we && in_range) begin
      frames[addr]  <= req.frame;
      offsets[addr] <= req.offset;
    end
  end

  // Registered read port; slots past the table depth read as zero.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_oob   <= !in_range;
      frame_q  <= frames[addr];
      offset_q <= offsets[addr];
    end
  end

  assign rd_frame  = rd_oob ? 32'd0 : frame_q;
  assign rd_offset = rd_oob ? 32'd0 : offset_q;

endmodule

`default_nettype wire

// ===== rtl/playback_transport_keyframe_seek.sv =====
// Top level: playback transport sequencer with keyframe table search.
//
//   Channel   Signals                          Direction  Contents
//   in        in_valid, in_ready, in_data      input      command transaction
//   out       out_valid, out_ready, out_data   output     transport status
//   cfg       cfg_wr_en, cfg_index, cfg_wr_data input     skip, frame and keyframe counts
//
// Skips walk the table one keyframe at a time, with one read of the single memory
// port and one compare in the shared unit for each slot the walk steps over.
// Reset clears mode, position and keyframe tracking; the table is not cleared.
// The block takes one transaction at a time; a finished result waits in the
// output register while the next transaction is accepted and worked on.
`default_nettype none

module playback_transport_keyframe_seek
  import pbks_pkg::*;
#(
  parameter int MAX_KEYFRAMES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wr_data
);

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_DECODE    = 14'b00000000000010,
    S_FWD_SUM   = 14'b00000000000100,
    S_FWD_CHK   = 14'b00000000001000,
    S_BWD_SUB   = 14'b00000000010000,
    S_SRCH_RD   = 14'b00000000100000,
    S_SRCH_WAIT = 14'b00000001000000,
    S_JUMP_RD   = 14'b00000010000000,
    S_JUMP_WAIT = 14'b00000100000000,
    S_SHOW_RD   = 14'b00001000000000,
    S_SHOW_WAIT = 14'b00010000000000,
    S_SHOW_INC  = 14'b00100000000000,
    S_SHOW_END  = 14'b01000000000000,
    S_FINISH    = 14'b10000000000000
  } state_t;

  state_t      state;
  state_t      state_next;

  // Configuration registers.
  logic [15:0] skip_length;
  logic [31:0] frame_count;
  logic [8:0]  keyframe_count;

  // Transport state.
  logic [1:0]  mode;
  logic [31:0] position;
  logic [7:0]  last_kf;
  logic [8:0]  next_kf;

  // Per-transaction working registers.
  in_item_t    item;
  logic [31:0] target;
  logic        target_hi;
  logic [8:0]  idx;
  logic        srch_fwd;
  logic        shown;
  logic        hit_end;
  logic        sought;
  logic [31:0] sought_offset;

  logic [8:0]  search_lim;
  logic        srch_go;
  logic [1:0]  mode_final;
  logic        out_load;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  kf_req_t     kf_req;
  logic [31:0] rd_frame;
  logic [31:0] rd_offset;

  pbks_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  pbks_kfmem #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES)
  ) u_kfmem (
    .clk       (clk),
    .req       (kf_req),
    .rd_frame  (rd_frame),
    .rd_offset (rd_offset)
  );

  assign in_ready   = (state == S_IDLE);
  assign search_lim = (keyframe_count == 9'd0) ? 9'd0 : keyframe_count - 9'd1;
  assign srch_go    = srch_fwd ? (idx < search_lim) : (idx != 9'd0);
  assign mode_final = (hit_end && mode == MODE_PLAYING) ? MODE_ENDED : mode;
  assign out_load   = (state == S_FINISH) && (!out_valid || out_ready);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_length    <= 16'd48;
      frame_count    <= 32'd1;
      keyframe_count <= 9'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SKIP_LENGTH:    skip_length    <= cfg_wr_data[15:0];
        CFG_FRAME_COUNT:    frame_count    <= cfg_wr_data;
        CFG_KEYFRAME_COUNT: keyframe_count <= cfg_wr_data[8:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared arithmetic unit.
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = position;
    alu_req.b  = frame_count;
    case (state)
      S_FWD_SUM: begin
        alu_req.op = ALU_ADD;
        alu_req.b  = {16'd0, skip_length};
      end
      S_FWD_CHK: begin
        alu_req.a = target;
        alu_req.b = frame_count;
      end
      S_BWD_SUB: begin
        alu_req.b = {16'd0, skip_length};
      end
      S_SRCH_WAIT: begin
        alu_req.a = srch_fwd ? rd_frame : target;
        alu_req.b = srch_fwd ? target : rd_frame;
      end
      S_SHOW_WAIT: begin
        alu_req.b = rd_frame;
      end
      S_SHOW_INC: begin
        alu_req.op = ALU_ADD;
        alu_req.b  = 32'd1;
      end
      default: ;
    endcase
  end

  // Keyframe table port: writes from table-write commands, reads by the sequencer.
  always_comb begin
    kf_req.we     = (state == S_DECODE) && (item.cmd == CMD_WRITE_ENTRY);
    kf_req.re     = 1'b0;
    kf_req.slot   = {1'b0, item.entry_slot};
    kf_req.frame  = item.entry_frame;
    kf_req.offset = item.entry_offset;
    case (state)
      S_SRCH_RD: begin
        kf_req.re   = srch_go;
        kf_req.slot = idx;
      end
      S_JUMP_RD: begin
        kf_req.re   = 1'b1;
        kf_req.slot = idx;
      end
      S_SHOW_RD: begin
        kf_req.re   = 1'b1;
        kf_req.slot = next_kf;
      end
      default: ;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (item.cmd)
          CMD_RESTART:   state_next = S_JUMP_RD;
          CMD_SKIP_FWD:  state_next = (mode == MODE_ENDED) ? S_FINISH : S_FWD_SUM;
          CMD_SKIP_BACK: state_next = S_BWD_SUB;
          CMD_TICK:      state_next = (mode == MODE_PLAYING) ? S_SHOW_RD : S_FINISH;
          default:       state_next = S_FINISH;
        endcase
      end
      S_FWD_SUM: state_next = S_FWD_CHK;
      S_FWD_CHK: begin
        if (alu_rsp.carry) begin
          state_next = S_SRCH_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_BWD_SUB: state_next = alu_rsp.carry ? S_JUMP_RD : S_SRCH_RD;
      S_SRCH_RD: state_next = srch_go ? S_SRCH_WAIT : S_JUMP_RD;
      S_SRCH_WAIT: state_next = alu_rsp.carry ? S_SRCH_RD : S_JUMP_RD;
      S_JUMP_RD: state_next = S_JUMP_WAIT;
      S_JUMP_WAIT: state_next = S_SHOW_RD;
      S_SHOW_RD: state_next = item.frame_ready ? S_SHOW_WAIT : S_FINISH;
      S_SHOW_WAIT: state_next = S_SHOW_INC;
      S_SHOW_INC: state_next = S_SHOW_END;
      S_SHOW_END: state_next = S_FINISH;
      S_FINISH: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // The forward skip also fails when the sum itself overflowed 32 bits.
    if (state == S_FWD_CHK && target_hi) state_next = S_FINISH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Transport state and per-transaction working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_PAUSED;
      position <= 32'd0;
      last_kf  <= 8'd0;
      next_kf  <= 9'd1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) item <= in_data;
        end
        S_DECODE: begin
          shown         <= 1'b0;
          hit_end       <= 1'b0;
          sought        <= 1'b0;
          sought_offset <= 32'd0;
          idx           <= {1'b0, last_kf};
          case (item.cmd)
            CMD_RESTART: begin
              mode <= MODE_PAUSED;
              idx  <= 9'd0;
            end
            CMD_PLAY_PAUSE: begin
              if (mode == MODE_PAUSED) begin
                mode <= MODE_PLAYING;
              end else if (mode == MODE_PLAYING) begin
                mode <= MODE_PAUSED;
              end
            end
            CMD_SKIP_FWD: srch_fwd <= 1'b1;
            CMD_SKIP_BACK: begin
              srch_fwd <= 1'b0;
              if (mode == MODE_ENDED) mode <= MODE_PAUSED;
            end
            default: ;
          endcase
        end
        S_FWD_SUM: begin
          target    <= alu_rsp.res;
          target_hi <= alu_rsp.carry;
        end
        S_FWD_CHK: begin
          // Landing at or past the frame count pauses playback instead of seeking.
          if (target_hi || !alu_rsp.carry) begin
            if (mode == MODE_PLAYING) mode <= MODE_PAUSED;
          end
        end
        S_BWD_SUB: begin
          target <= alu_rsp.res;
          if (alu_rsp.carry) idx <= 9'd0;
        end
        S_SRCH_WAIT: begin
          if (alu_rsp.carry) idx <= srch_fwd ? idx + 9'd1 : idx - 9'd1;
        end
        S_JUMP_WAIT: begin
          sought        <= 1'b1;
          sought_offset <= rd_offset;
          position      <= (item.cmd == CMD_RESTART) ? 32'd0 : rd_frame;
          last_kf       <= idx[7:0];
          next_kf       <= idx + 9'd1;
        end
        S_SHOW_WAIT: begin
          // Crossing the next keyframe moves both keyframe pointers on.
          if (next_kf < keyframe_count && alu_rsp.zero) begin
            last_kf <= last_kf + 8'd1;
            next_kf <= next_kf + 9'd1;
          end
        end
        S_SHOW_INC: begin
          position <= alu_rsp.res;
          shown    <= 1'b1;
        end
        S_SHOW_END: begin
          if (alu_rsp.zero) hit_end <= 1'b1;
        end
        S_FINISH: begin
          if (out_load) mode <= mode_final;
        end
        default: ;
      endcase
    end
  end

  // Output register; the next transaction proceeds while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.play_state       <= mode_final;
      out_data.shown_frame      <= position;
      out_data.seek_valid       <= sought;
      out_data.seek_offset      <= sought ? sought_offset : 32'd0;
      out_data.frame_advanced   <= shown;
      out_data.reached_end      <= hit_end;
      out_data.current_keyframe <= last_kf;
    end
  end

`ifndef SYNTHESIS
  // The next keyframe always sits one slot past the last one.
  a_kf_pair: assert property (@(posedge clk) disable iff (rst)
    next_kf[7:0] == last_kf + 8'd1)
    else $error("keyframe pointers out of step");

  // An accepted transaction makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // A reported end of video implies a frame was shown in that transaction.
  a_end_shown: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reached_end |-> out_data.frame_advanced)
    else $error("end reached without a displayed frame");

  // No offset is reported without a seek.
  a_seek_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.seek_valid |-> out_data.seek_offset == 32'd0)
    else $error("seek offset without seek");
`endif

endmodule

`default_nettype wire
